// ===== rtl/bale_pkg.sv =====
package bale_pkg;

  localparam int unsigned Capacity = 8;
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned LenW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    REQ_APPEND     = 3'd0,
    REQ_INSERT_AT  = 3'd1,
    REQ_REMOVE_ONE = 3'd2,
    REQ_REMOVE_AT  = 3'd3,
    REQ_REMOVE_ALL = 3'd4,
    REQ_ADD_TERM   = 3'd5,
    REQ_SUM        = 3'd6,
    REQ_GET        = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [3:0]         found_position;
    logic [3:0]         match_count;
    logic [1:0]         status;
    logic [3:0]         list_length;
  } rsp_t;

endpackage

// ===== rtl/bounded_array_list_engine_top.sv =====
// Channel | Direction | Payload              | Handshake
// req     | in        | bale_pkg::req_t      | req_valid_i / req_ready_o
// rsp     | out       | bale_pkg::rsp_t      | rsp_valid_o / rsp_ready_i
// One request at a time. Each walk reads one entry per cycle through the
// registered RAM read port, and the response is registered once the walk ends.
// Reset clears the length and the control; entries stay undefined.
// A waiting response holds in its register and blocks req_ready_o; the next
// request beat lands in the cycle after the response beat at the earliest.
module bounded_array_list_engine_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bale_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output bale_pkg::rsp_t rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  localparam int unsigned IdxW = bale_pkg::IdxW;
  localparam int unsigned LenW = bale_pkg::LenW;

  state_e               state_q, state_d;
  logic [LenW-1:0]      len_q, len_d;
  bale_pkg::req_t       req_q;
  logic [LenW-1:0]      rd_q, rd_d;   // next read index
  logic [LenW-1:0]      wr_q, wr_d;   // compaction write index
  logic [LenW-1:0]      end_q, end_d; // walk end
  logic                 first_q, first_d;
  logic                 hit_q, hit_d;
  logic [LenW-1:0]      cnt_q, cnt_d;
  logic [LenW-1:0]      fpos_q, fpos_d;
  logic [31:0]          acc_q, acc_d;
  logic [31:0]          prev_q, prev_d;
  logic [1:0]           st_q, st_d;
  logic                 rsp_valid_q;
  bale_pkg::rsp_t       rsp_q;

  logic                 we;
  logic [IdxW-1:0]      waddr, raddr;
  logic [31:0]          wdata, rdata;
  logic                 rvalid_q, rvalid_d;
  logic [LenW-1:0]      ridx_q;

  logic [LenW-1:0]      pos_ext;
  logic                 pos_ok, full;
  logic                 accept;

  bale_ram #(.Depth(bale_pkg::Capacity), .AddrW(IdxW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign pos_ext = LenW'(req_q.position);
  assign pos_ok  = (req_q.position != 4'd0) && (5'(req_q.position) <= 5'(len_q));
  assign full    = (len_q == LenW'(bale_pkg::Capacity));

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    end_d    = end_q;
    first_d  = first_q;
    hit_d    = hit_q;
    cnt_d    = cnt_q;
    fpos_d   = fpos_q;
    acc_d    = acc_q;
    prev_d   = prev_q;
    st_d     = st_q;
    rvalid_d = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = req_q.value;
    raddr    = rd_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_WALK;
          first_d = 1'b1;
        end
      end
      S_WALK: begin
        if (first_q) begin
          first_d = 1'b0;
          hit_d   = 1'b0;
          cnt_d   = '0;
          fpos_d  = '0;
          acc_d   = '0;
          st_d    = bale_pkg::ST_OK;
          rd_d    = '0;
          wr_d    = '0;
          end_d   = len_q;
          case (bale_pkg::req_e'(req_q.req_type))
            bale_pkg::REQ_APPEND: begin
              if (full) begin
                st_d = bale_pkg::ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = len_q[IdxW-1:0];
                len_d = len_q + 1'b1;
              end
              state_d = S_DONE;
            end
            bale_pkg::REQ_INSERT_AT: begin
              if (full) begin
                st_d    = bale_pkg::ST_FULL;
                state_d = S_DONE;
              end else if (!pos_ok) begin
                st_d    = bale_pkg::ST_RANGE;
                state_d = S_DONE;
              end else begin
                rd_d  = pos_ext - 1'b1;
                wr_d  = pos_ext - 1'b1;
                end_d = len_q;
                // carry the new word in prev; shift it upward
                prev_d = req_q.value;
              end
            end
            bale_pkg::REQ_REMOVE_ONE: begin
              if (len_q == '0) st_d = bale_pkg::ST_NOTFOUND;
            end
            bale_pkg::REQ_REMOVE_AT, bale_pkg::REQ_GET: begin
              if (!pos_ok) begin
                st_d    = bale_pkg::ST_RANGE;
                state_d = S_DONE;
              end else begin
                rd_d = pos_ext - 1'b1;
              end
            end
            default: ;
          endcase
          if (state_d == S_WALK) begin
            raddr    = rd_d[IdxW-1:0];
            rvalid_d = (rd_d < end_d);
            rd_d     = rd_d + 1'b1;
            if (rd_d > end_d && bale_pkg::req_e'(req_q.req_type) != bale_pkg::REQ_INSERT_AT)
              state_d = S_DONE;
          end
        end else begin
          if (rvalid_q) begin
            case (bale_pkg::req_e'(req_q.req_type))
              bale_pkg::REQ_INSERT_AT: begin
                we     = 1'b1;
                waddr  = ridx_q[IdxW-1:0];
                wdata  = prev_q;
                prev_d = rdata;
              end
              bale_pkg::REQ_REMOVE_ONE, bale_pkg::REQ_REMOVE_AT: begin
                if (hit_q) begin
                  we    = 1'b1;
                  waddr = IdxW'(ridx_q - 1'b1);
                  wdata = rdata;
                end else if ((bale_pkg::req_e'(req_q.req_type) == bale_pkg::REQ_REMOVE_AT)
                             || (rdata == req_q.value)) begin
                  hit_d  = 1'b1;
                  acc_d  = rdata;
                  if (bale_pkg::req_e'(req_q.req_type) == bale_pkg::REQ_REMOVE_ONE)
                    fpos_d = ridx_q + 1'b1;
                end
              end
              bale_pkg::REQ_REMOVE_ALL: begin
                if (rdata == req_q.value) begin
                  cnt_d = cnt_q + 1'b1;
                end else begin
                  we    = 1'b1;
                  waddr = wr_q[IdxW-1:0];
                  wdata = rdata;
                  wr_d  = wr_q + 1'b1;
                end
              end
              bale_pkg::REQ_ADD_TERM: begin
                we    = 1'b1;
                waddr = ridx_q[IdxW-1:0];
                wdata = rdata + req_q.value;
              end
              bale_pkg::REQ_SUM: acc_d = acc_q + rdata;
              bale_pkg::REQ_GET: acc_d = rdata;
              default: ;
            endcase
          end
          if (bale_pkg::req_e'(req_q.req_type) == bale_pkg::REQ_GET
              || bale_pkg::req_e'(req_q.req_type) == bale_pkg::REQ_APPEND) begin
            state_d = S_DONE;
          end else if (rd_q < end_q) begin
            rvalid_d = 1'b1;
            rd_d     = rd_q + 1'b1;
          end else if (bale_pkg::req_e'(req_q.req_type) == bale_pkg::REQ_INSERT_AT
                       && !rvalid_q && rd_q == end_q) begin
            // last word lands one past the old end
            we      = 1'b1;
            waddr   = end_q[IdxW-1:0];
            wdata   = prev_q;
            len_d   = len_q + 1'b1;
            state_d = S_DONE;
          end else if (!rvalid_q) begin
            state_d = S_DONE;
            case (bale_pkg::req_e'(req_q.req_type))
              bale_pkg::REQ_REMOVE_ONE: begin
                if (hit_q) len_d = len_q - 1'b1;
                else st_d = bale_pkg::ST_NOTFOUND;
              end
              bale_pkg::REQ_REMOVE_AT: len_d = len_q - 1'b1;
              bale_pkg::REQ_REMOVE_ALL: len_d = wr_q;
              default: ;
            endcase
          end
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      rvalid_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rvalid_q <= rvalid_d;
      first_q  <= first_d;
      if (state_q == S_DONE) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    ridx_q <= rvalid_d ? rd_d - 1'b1 : rd_q;
    rd_q   <= rd_d;
    wr_q   <= wr_d;
    end_q  <= end_d;
    hit_q  <= hit_d;
    cnt_q  <= cnt_d;
    fpos_q <= fpos_d;
    acc_q  <= acc_d;
    prev_q <= prev_d;
    st_q   <= st_d;
    if (state_q == S_DONE) begin
      rsp_q.result_value   <= acc_q;
      rsp_q.found_position <= 4'(fpos_q);
      rsp_q.match_count    <= 4'(cnt_q);
      rsp_q.status         <= st_q;
      rsp_q.list_length    <= 4'(len_q);
    end
  end

endmodule

// ===== rtl/bale_ram.sv =====
module bale_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/bale_checker.sv =====
module bale_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input bale_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input bale_pkg::rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("rsp beat dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("req taken while busy");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> 5'(rsp_o.list_length) <= 5'(bale_pkg::Capacity))
    else $error("length over capacity");

  a_no_rsp_with_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("req ready with rsp pending");

endmodule

bind bounded_array_list_engine_top bale_checker u_bale_checker (.*);

// ===== tb/sv/bounded_array_list_engine_top_tb.sv =====
`timescale 1ns / 100ps

module bounded_array_list_engine_top_tb;

  class list_scoreboard;
    logic [31:0] words [bale_pkg::Capacity];
    int unsigned count;
    bale_pkg::rsp_t pending_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function void clear();
      count = 0;
      mismatches = 0;
      checked = 0;
      pending_q.delete();
    endfunction

    function void note_request(bale_pkg::req_t r);
      bale_pkg::rsp_t e;
      int unsigned w;
      int unsigned n;
      bit pos_ok;
      e = '0;
      e.status = bale_pkg::ST_OK;
      pos_ok = (r.position >= 1) && (r.position <= count);
      case (bale_pkg::req_e'(r.req_type))
        bale_pkg::REQ_APPEND: begin
          if (count >= bale_pkg::Capacity) e.status = bale_pkg::ST_FULL;
          else begin
            words[count] = r.value;
            count++;
          end
        end
        bale_pkg::REQ_INSERT_AT: begin
          if (count >= bale_pkg::Capacity) e.status = bale_pkg::ST_FULL;
          else if (!pos_ok) e.status = bale_pkg::ST_RANGE;
          else begin
            for (int i = count; i > r.position - 1; i--) words[i] = words[i-1];
            words[r.position-1] = r.value;
            count++;
          end
        end
        bale_pkg::REQ_REMOVE_ONE: begin
          e.status = bale_pkg::ST_NOTFOUND;
          for (int i = 0; i < count; i++) begin
            if (words[i] == r.value) begin
              e.found_position = 4'(i + 1);
              e.result_value = r.value;
              e.status = bale_pkg::ST_OK;
              for (int j = i; j + 1 < count; j++) words[j] = words[j+1];
              count--;
              break;
            end
          end
        end
        bale_pkg::REQ_REMOVE_AT: begin
          if (!pos_ok) e.status = bale_pkg::ST_RANGE;
          else begin
            e.result_value = words[r.position-1];
            for (int j = r.position - 1; j + 1 < count; j++) words[j] = words[j+1];
            count--;
          end
        end
        bale_pkg::REQ_REMOVE_ALL: begin
          w = 0;
          n = 0;
          for (int i = 0; i < count; i++) begin
            if (words[i] == r.value) n++;
            else begin
              words[w] = words[i];
              w++;
            end
          end
          count = w;
          e.match_count = 4'(n);
        end
        bale_pkg::REQ_ADD_TERM:
          for (int i = 0; i < count; i++) words[i] = words[i] + r.value;
        bale_pkg::REQ_SUM: for (int i = 0; i < count; i++) e.result_value += words[i];
        default: begin
          if (!pos_ok) e.status = bale_pkg::ST_RANGE;
          else e.result_value = words[r.position-1];
        end
      endcase
      e.list_length = 4'(count);
      pending_q.push_back(e);
    endfunction

    function void check_response(bale_pkg::rsp_t a);
      bale_pkg::rsp_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", a);
        return;
      end
      e = pending_q.pop_front();
      if (a.result_value !== e.result_value || a.found_position !== e.found_position ||
          a.match_count !== e.match_count || a.status !== e.status ||
          a.list_length !== e.list_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value %h/%h pos %0d/%0d cnt %0d/%0d st %0d/%0d len %0d/%0d",
                   e.result_value, a.result_value, e.found_position, a.found_position,
                   e.match_count, a.match_count, e.status, a.status,
                   e.list_length, a.list_length);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  bale_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  bale_pkg::rsp_t rsp_o;

  list_scoreboard sb;
  int unsigned cycles;
  bit hold_rsp;
  bit rsp_busy;
  int unsigned op_hits[8];
  logic [31:0] recent_q[$];

  localparam int unsigned CycleLimit = 400000;

  always #5 clk_i = ~clk_i;

  bounded_array_list_engine_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("bounded_array_list_engine_top test failed");
      $finish;
    end
    if (rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
  end

  initial begin
    int unsigned w;
    cycles = 0;
    forever begin
      @(negedge clk_i);
      if (rsp_busy) continue;
      if (hold_rsp) begin
        rsp_ready_i <= 1'b0;
        continue;
      end
      if (rsp_ready_i && rsp_valid_o) begin
        w = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
          rsp_busy = 1;
          rsp_ready_i <= 1'b0;
          repeat (w) @(negedge clk_i);
          rsp_busy = 0;
        end
      end
      rsp_ready_i <= 1'b1;
    end
  end

  task automatic send_request(bale_pkg::req_e op, logic [31:0] val, logic [3:0] pos);
    bale_pkg::req_t r;
    r.req_type = op;
    r.value = val;
    r.position = pos;
    req_i <= r;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
    op_hits[op]++;
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    req_valid_i <= 1'b0;
  endtask

  task automatic send_with_gap(bale_pkg::req_e op, logic [31:0] val, logic [3:0] pos);
    int unsigned g;
    g = $urandom_range(0, 4);
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      go_idle();
      repeat (g) @(negedge clk_i);
    end
    send_request(op, val, pos);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3);
      3: if (recent_q.size() > 0) return recent_q[$urandom_range(0, recent_q.size() - 1)];
      default: ;
    endcase
    return $urandom;
  endfunction

  task automatic send_random();
    bale_pkg::req_e op;
    logic [31:0] v;
    logic [3:0] p;
    op = bale_pkg::req_e'($urandom_range(0, 7));
    if (sb.count < 4 && $urandom_range(0, 2) == 0) op = bale_pkg::REQ_APPEND;
    v = pick_value();
    if ($urandom_range(0, 7) == 0) p = 4'($urandom_range(0, 15));
    else p = 4'($urandom_range(0, sb.count + 1));
    if (op == bale_pkg::REQ_APPEND || op == bale_pkg::REQ_INSERT_AT) begin
      recent_q.push_back(v);
      if (recent_q.size() > 6) void'(recent_q.pop_front());
    end
    send_with_gap(op, v, p);
  endtask

  task automatic drain();
    go_idle();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    sb.clear();
    hold_rsp = 0;
    rsp_busy = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(bale_pkg::REQ_SUM, 32'h0, 4'd0);
    send_request(bale_pkg::REQ_ADD_TERM, 32'h5, 4'd0);
    send_request(bale_pkg::REQ_GET, 32'h0, 4'd1);
    send_request(bale_pkg::REQ_REMOVE_AT, 32'h0, 4'd1);
    send_request(bale_pkg::REQ_REMOVE_ONE, 32'h5, 4'd0);
    send_request(bale_pkg::REQ_REMOVE_ALL, 32'h5, 4'd0);
    send_request(bale_pkg::REQ_INSERT_AT, 32'h1, 4'd1);
    send_request(bale_pkg::REQ_APPEND, 32'h7fff_ffff, 4'd0);
    send_request(bale_pkg::REQ_APPEND, 32'h8000_0000, 4'd0);
    send_request(bale_pkg::REQ_INSERT_AT, 32'hffff_ffff, 4'd1);
    send_request(bale_pkg::REQ_INSERT_AT, 32'h5555_aaaa, 4'd3);
    for (int i = 0; i < 4; i++) send_request(bale_pkg::REQ_APPEND, 32'h5, 4'd0);
    send_request(bale_pkg::REQ_APPEND, 32'h1, 4'd0);
    send_request(bale_pkg::REQ_INSERT_AT, 32'h1, 4'd1);
    send_request(bale_pkg::REQ_GET, 32'h0, 4'd8);
    send_request(bale_pkg::REQ_GET, 32'h0, 4'd15);
    send_request(bale_pkg::REQ_SUM, 32'h0, 4'd0);
    send_request(bale_pkg::REQ_ADD_TERM, 32'h7fff_ffff, 4'd0);
    send_request(bale_pkg::REQ_REMOVE_ALL, 32'h8000_0004, 4'd0);
    send_request(bale_pkg::REQ_REMOVE_ONE, 32'h1234, 4'd0);
    send_request(bale_pkg::REQ_REMOVE_AT, 32'h0, 4'd0);
    send_request(bale_pkg::REQ_REMOVE_AT, 32'h0, 4'd1);

    for (int n = 0; n < 1330; n++) begin
      if (n == 300) begin
        hold_rsp = 1;
        fork
          begin
            repeat (200) @(negedge clk_i);
            hold_rsp = 0;
          end
        join_none
      end
      if (n == 700) drain();
      send_random();
    end

    drain();
    repeat (30) @(negedge clk_i);
    $display("covered %0d responses; ops append..get: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.checked, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
             op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("bounded_array_list_engine_top test passed");
    else
      $display("bounded_array_list_engine_top test failed");
    $finish;
  end

endmodule
